// ===== rtl/psms_pkg.sv =====
// Package for the point set mean / standard deviation block: types and constants.
package psms_pkg;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned CoordW = 24;
  localparam int unsigned CountW = 11;
  localparam int unsigned SumW = 34;
  localparam int unsigned SqW = 58;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic last_point;
  } point_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] mean_x;
    logic signed [CoordW-1:0] mean_y;
    logic signed [CoordW-1:0] mean_z;
    logic [CoordW-1:0] std_x;
    logic [CoordW-1:0] std_y;
    logic [CoordW-1:0] std_z;
    logic [CountW-1:0] points_used;
    logic overflowed;
  } stats_out_t;

endpackage

// ===== rtl/psms_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module psms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/psms_divsqrt.sv =====
// Iterative unit: unsigned restoring division and integer square root.
module psms_divsqrt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic is_sqrt,
  input  logic [63:0] num,
  input  logic [16:0] den,
  output logic busy,
  output logic [63:0] res
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] work;
  logic [6:0] step;
  logic mode;
  logic [64:0] trial;
  logic [65:0] strial;

  always_comb begin
    trial = {rem[63:0], work[63]} - {48'd0, den};
    strial = {rem, work[63:62]} - {quo, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      mode <= is_sqrt;
      work <= num;
      rem <= '0;
      quo <= '0;
      step <= is_sqrt ? 7'd32 : 7'd64;
    end else if (busy) begin
      if (mode) begin
        work <= {work[61:0], 2'b00};
        if (!strial[65]) begin
          rem <= strial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[61:0], work[63:62]};
          quo <= {quo[62:0], 1'b0};
        end
      end else begin
        work <= {work[62:0], 1'b0};
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], work[63]};
          quo <= {quo[62:0], 1'b0};
        end
      end
      step <= step - 7'd1;
      if (step == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign res = quo;

endmodule

// ===== rtl/point_set_mean_stddev.sv =====
// Top level: stores a point set, then gives per-axis mean and population std deviation.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | psms_pkg::point_in_t
//  out     | out | out_valid/out_ready| psms_pkg::stats_out_t
//
// A non-final point is stored and summed when accepted. The final point starts a sequencer:
// three mean divisions, one memory sweep over the stored points, then per axis a division
// and a square root, all run on the iterative divider and root unit. Reset clears counters
// and sums; the point memory holds junk until written. A result waiting on out_ready stalls
// only the next final point.
module point_set_mean_stddev #(
  parameter int unsigned MaxPoints = psms_pkg::MaxPoints
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  psms_pkg::point_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output psms_pkg::stats_out_t out_data
);

  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned CW = psms_pkg::CoordW;
  localparam int unsigned SumLW = CW + CntW;
  localparam int unsigned SqLW = 2 * CW + CntW;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_MEAN = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_VAR = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;

  logic [2:0] state;
  logic [CntW-1:0] count;
  logic drop;
  logic signed [SumLW-1:0] sums [3];
  logic [SqLW-1:0] sqs [3];
  logic signed [CW-1:0] means [3];
  logic [CW-1:0] stds [3];
  logic [1:0] axis;
  logic started;
  logic [CntW-1:0] rd_idx;
  logic rd_valid;
  logic [3*CW-1:0] rdata;
  logic du_start;
  logic du_sqrt;
  logic [63:0] du_num;
  logic du_busy;
  logic [63:0] du_res;
  logic accept;
  logic store_ok;
  logic [63:0] abs_sum;
  logic sum_neg;

  assign in_ready = (state == S_LOAD) && !(out_valid && in_data.last_point);
  assign accept = in_valid && in_ready;
  assign store_ok = count < CntW'(MaxPoints);

  psms_ram #(.Width(3 * CW), .Depth(MaxPoints)) u_store (
    .clk(clk),
    .we(accept && store_ok),
    .waddr(count[AddrW-1:0]),
    .wdata({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .raddr(rd_idx[AddrW-1:0]),
    .rdata(rdata)
  );

  psms_divsqrt u_unit (
    .clk(clk),
    .rst(rst),
    .start(du_start),
    .is_sqrt(du_sqrt),
    .num(du_num),
    .den(17'(count)),
    .busy(du_busy),
    .res(du_res)
  );

  assign sum_neg = sums[axis][SumLW-1];
  assign abs_sum = sum_neg ? -64'(sums[axis]) : 64'(sums[axis]);

  always_comb begin
    du_start = 1'b0;
    du_sqrt = 1'b0;
    du_num = abs_sum;
    if (state == S_MEAN && !started) begin
      du_start = 1'b1;
    end else if (state == S_VAR && !started) begin
      du_start = 1'b1;
      du_num = 64'(sqs[axis]);
    end else if (state == S_ROOT && !started) begin
      du_start = 1'b1;
      du_sqrt = 1'b1;
      du_num = du_res;
    end
  end

  logic signed [CW:0] diff [3];
  logic [2*CW+1:0] sq [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = $signed({rdata[(2-a)*CW+CW-1], rdata[(2-a)*CW +: CW]}) -
                $signed({means[a][CW-1], means[a]});
      sq[a] = (2*CW+2)'($signed(diff[a]) * $signed(diff[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      drop <= 1'b0;
      out_valid <= 1'b0;
      started <= 1'b0;
      axis <= '0;
      rd_idx <= '0;
      rd_valid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        sums[a] <= '0;
        sqs[a] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              count <= count + 1'b1;
              sums[0] <= sums[0] + SumLW'(in_data.coord_x);
              sums[1] <= sums[1] + SumLW'(in_data.coord_y);
              sums[2] <= sums[2] + SumLW'(in_data.coord_z);
            end else begin
              drop <= 1'b1;
            end
            if (in_data.last_point) begin
              state <= S_MEAN;
              axis <= '0;
              started <= 1'b0;
            end
          end
        end
        S_MEAN: begin
          if (!started) begin
            started <= 1'b1;
          end else if (!du_busy) begin
            means[axis] <= sum_neg ? CW'(-du_res) : CW'(du_res);
            started <= 1'b0;
            if (axis == 2'd2) begin
              axis <= '0;
              state <= S_SWEEP;
              rd_idx <= '0;
              rd_valid <= 1'b0;
            end else begin
              axis <= axis + 1'b1;
            end
          end
        end
        S_SWEEP: begin
          rd_valid <= rd_idx < count;
          if (rd_idx < count) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (rd_valid) begin
            for (int a = 0; a < 3; a++) begin
              sqs[a] <= sqs[a] + SqLW'(sq[a]);
            end
          end else if (rd_idx == count && rd_idx != '0) begin
            state <= S_VAR;
            started <= 1'b0;
          end
        end
        S_VAR: begin
          if (!started) begin
            started <= 1'b1;
          end else if (!du_busy) begin
            state <= S_ROOT;
            started <= 1'b0;
          end
        end
        S_ROOT: begin
          if (!started) begin
            started <= 1'b1;
          end else if (!du_busy) begin
            stds[axis] <= CW'(du_res);
            started <= 1'b0;
            if (axis == 2'd2) begin
              state <= S_LOAD;
              axis <= '0;
              out_valid <= 1'b1;
              out_data.mean_x <= means[0];
              out_data.mean_y <= means[1];
              out_data.mean_z <= means[2];
              out_data.std_x <= stds[0];
              out_data.std_y <= stds[1];
              out_data.std_z <= CW'(du_res);
              out_data.points_used <= psms_pkg::CountW'(count);
              out_data.overflowed <= drop;
              count <= '0;
              drop <= 1'b0;
              for (int a = 0; a < 3; a++) begin
                sums[a] <= '0;
                sqs[a] <= '0;
              end
            end else begin
              axis <= axis + 1'b1;
              state <= S_VAR;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== rtl/psms_checker.sv =====
// Port-level checker for the point set statistics block, bound to the top level.
module psms_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input psms_pkg::point_in_t in_data,
  input logic out_valid,
  input logic out_ready,
  input psms_pkg::stats_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_used_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.points_used != '0)
    else $error("result with no points");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_point |=> !in_ready)
    else $error("input taken during second pass");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind point_set_mean_stddev psms_checker u_psms_checker (.*);

// ===== test/point_set_mean_stddev_tb.sv =====
// Testbench for point_set_mean_stddev: random point sets checked against a two-pass predictor.
module point_set_mean_stddev_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class stats_board;
    logic signed [psms_pkg::CoordW-1:0] pts[$][3];
    bit dropped;
    psms_pkg::stats_out_t pending[$];
    int errors;

    function new();
      dropped = 0;
      errors = 0;
    endfunction

    function logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_point(psms_pkg::point_in_t p);
      psms_pkg::stats_out_t s;
      logic signed [psms_pkg::CoordW-1:0] pt[3];
      longint sum, mean, d;
      logic [63:0] sq;
      int n;
      if (pts.size() < psms_pkg::MaxPoints) begin
        pt[0] = p.coord_x;
        pt[1] = p.coord_y;
        pt[2] = p.coord_z;
        pts.insert(pts.size(), pt);
      end else dropped = 1;
      if (!p.last_point) return;
      n = pts.size();
      for (int a = 0; a < 3; a++) begin
        sum = 0;
        foreach (pts[i]) sum += longint'(pts[i][a]);
        mean = sum / n;
        sq = 0;
        foreach (pts[i]) begin
          d = longint'(pts[i][a]) - mean;
          if (d < 0) d = -d;
          sq += 64'(d) * 64'(d);
        end
        sq = root_floor(sq / n);
        case (a)
          0: begin s.mean_x = mean[23:0]; s.std_x = sq[23:0]; end
          1: begin s.mean_y = mean[23:0]; s.std_y = sq[23:0]; end
          default: begin s.mean_z = mean[23:0]; s.std_z = sq[23:0]; end
        endcase
      end
      s.points_used = n[psms_pkg::CountW-1:0];
      s.overflowed = dropped;
      pending.insert(pending.size(), s);
      pts.delete();
      dropped = 0;
    endfunction

    function void check_stats(psms_pkg::stats_out_t got);
      psms_pkg::stats_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.mean_x !== e.mean_x || got.mean_y !== e.mean_y || got.mean_z !== e.mean_z ||
          got.std_x !== e.std_x || got.std_y !== e.std_y || got.std_z !== e.std_z ||
          got.points_used !== e.points_used || got.overflowed !== e.overflowed) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", e, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  psms_pkg::point_in_t in_data = '0;
  psms_pkg::stats_out_t out_data;
  stats_board sb = new();
  longint cycles = 0;
  int burst = 0, gap = 0;
  bit out_stall_mode = 0;

  point_set_mean_stddev uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("FAIL");
      $finish;
    end
    if (!rst && out_valid && out_ready) sb.check_stats(out_data);
  end

  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) out_stall_mode = !out_stall_mode;
      out_ready <= out_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  function automatic logic [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(0, 255) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_point(psms_pkg::point_in_t p);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
      gap = 0;
    end
    in_valid <= 1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_point(p);
    @(negedge clk);
    if (burst > 0) burst--;
    else begin
      burst = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  task automatic send_set(int n, int mode);
    psms_pkg::point_in_t p;
    for (int i = 0; i < n; i++) begin
      p.coord_x = rand_coord(mode);
      p.coord_y = rand_coord(mode == 0 ? 1 : mode);
      p.coord_z = rand_coord(mode == 1 ? 0 : mode);
      p.last_point = (i == n - 1);
      send_point(p);
    end
  endtask

  initial begin
    int total;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_set(1, 0);
    send_set(1, 1);
    send_set(2, 3);
    send_set(3, 0);
    send_set(4, 1);
    send_set(5, 2);
    send_set(psms_pkg::MaxPoints + 3, 3);
    total = 16 + psms_pkg::MaxPoints + 3;
    while (total < 1300) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      send_set(n, $urandom_range(0, 5) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 3));
      total += n;
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== point_set_mean_stddev.f =====
rtl/psms_pkg.sv
rtl/psms_ram.sv
rtl/psms_divsqrt.sv
rtl/point_set_mean_stddev.sv
rtl/psms_checker.sv
test/point_set_mean_stddev_tb.sv
